// File: rtl/atn_pkg.sv
// Shared constants, register indexes and saturation helper for the adaptive neuron step.
`default_nettype none

package atn_pkg;

  // Configuration port geometry
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEMBRANE_RATE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ADAPT_RATE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ADAPT_STRENGTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRE_THRESHOLD = 3'd4;

  // Register widths
  localparam int unsigned GAIN_W = 24;
  localparam int unsigned RATE_W = 17;
  localparam int unsigned VAL_W  = 32;

  // Register reset values
  localparam logic [GAIN_W-1:0]       RST_INPUT_GAIN     = 24'd655;
  localparam logic [RATE_W-1:0]       RST_MEMBRANE_RATE  = 17'd26214;
  localparam logic [RATE_W-1:0]       RST_ADAPT_RATE     = 17'd6554;
  localparam logic [GAIN_W-1:0]       RST_ADAPT_STRENGTH = 24'd458752;
  localparam logic signed [VAL_W-1:0] RST_FIRE_THRESHOLD = 32'sd11796;

  // Datapath widths: shared multiplier operands, product and adder
  localparam int unsigned OPA_W  = 41;
  localparam int unsigned OPB_W  = 25;
  localparam int unsigned PROD_W = 66;
  localparam int unsigned SAT_W  = 50;

  // Q16.16 one and the rounding offset for a shift by 16
  localparam logic signed [32:0]       Q_ONE = 33'sd65536;
  localparam logic signed [PROD_W-1:0] RND16 = 66'sd32768;

  localparam logic signed [SAT_W-1:0] S32_MAX_W = 50'sd2147483647;
  localparam logic signed [SAT_W-1:0] S32_MIN_W = -50'sd2147483648;

  // Clamp a wide signed value to the signed 32 bit range
  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > S32_MAX_W) begin
      r = 32'sh7fff_ffff;
    end else if (v < S32_MIN_W) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/atn_ifs.sv
// Valid/ready channel interfaces for neuron input items and tick results.
`default_nettype none

interface atn_item_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [31:0] weight;
  logic [15:0]        multiplicity;
  logic [3:0]         delay;

  modport source (output valid, output mode, output weight, output multiplicity,
                  output delay, input ready);
  modport sink   (input valid, input mode, input weight, input multiplicity,
                  input delay, output ready);
endinterface

interface atn_result_if;
  logic               valid;
  logic               ready;
  logic               spike;
  logic signed [31:0] membrane;
  logic signed [31:0] adaptation;

  modport source (output valid, output spike, output membrane, output adaptation,
                  input ready);
  modport sink   (input valid, input spike, input membrane, input adaptation,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/adaptive_threshold_neuron_step.sv
// Top level: adaptive-threshold integrate-and-fire neuron with a delay ring and shared multiplier.
//
//   channel    dir  handshake     payload
//   item_i     in   valid/ready   mode, weight, multiplicity, delay
//   result_o   out  valid/ready   spike, membrane, adaptation
//   cfg        in   cfg_we_i      cfg_idx_i, cfg_data_i (write only)
//
// A tick item runs through a load step and alternating multiply and add steps; a spike
// arrival through a multiply and a write step. The one 41 x 25 bit multiplier is used four
// times per tick, once per arrival. After reset a clearing pass zeroes the delay ring; no
// item is accepted meanwhile. A finished tick waits in its last step while a previous
// result is still held on result_o; new items are taken while a result waits.
`default_nettype none

module adaptive_threshold_neuron_step #(
  parameter int unsigned RING_DEPTH = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  atn_item_if.sink                             item_i,
  atn_result_if.source                         result_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [atn_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [atn_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned PW = atn_pkg::PROD_W;

  // Sequencer codes
  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_A_M  = 4'd2;
  localparam logic [3:0] ST_A_W  = 4'd3;
  localparam logic [3:0] ST_T_LD = 4'd4;
  localparam logic [3:0] ST_T_M1 = 4'd5;
  localparam logic [3:0] ST_T_D  = 4'd6;
  localparam logic [3:0] ST_T_M2 = 4'd7;
  localparam logic [3:0] ST_T_V  = 4'd8;
  localparam logic [3:0] ST_T_M3 = 4'd9;
  localparam logic [3:0] ST_T_F  = 4'd10;
  localparam logic [3:0] ST_T_M4 = 4'd11;
  localparam logic [3:0] ST_T_A  = 4'd12;

  // Configuration registers
  logic [atn_pkg::GAIN_W-1:0]       gain_q, alpha_q;
  logic [atn_pkg::RATE_W-1:0]       mrate_q, arate_q;
  logic signed [atn_pkg::VAL_W-1:0] theta_q;

  // Sequencer and neuron state
  logic [3:0]    state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [AW-1:0] slot_q, slot_d;
  logic signed [atn_pkg::VAL_W-1:0] vm_q, vm_d;
  logic signed [atn_pkg::VAL_W-1:0] om_q, om_d;
  logic fire_q, fire_d;

  // Shared multiplier operands and product
  logic signed [atn_pkg::OPA_W-1:0] opa_q, opa_d;
  logic signed [atn_pkg::OPB_W-1:0] opb_q, opb_d;
  logic signed [PW-1:0]             prod_q;
  logic                             mul_en;

  // Result holding register
  logic                             out_valid_q, out_valid_d;
  logic                             out_spike_q, out_spike_d;
  logic signed [atn_pkg::VAL_W-1:0] out_memb_q, out_memb_d;
  logic signed [atn_pkg::VAL_W-1:0] out_adapt_q, out_adapt_d;

  // Delay ring memory
  logic [atn_pkg::VAL_W-1:0]        ring_mem [RING_DEPTH];
  logic signed [atn_pkg::VAL_W-1:0] rd_q;
  logic                             mem_we, mem_re;
  logic [AW-1:0]                    mem_wa, mem_ra;
  logic [atn_pkg::VAL_W-1:0]        mem_wd;

  // Shared rounding adder
  logic signed [PW-1:0] add_rnd, add_b, add_sum;

  logic                 item_acc, out_load;
  logic [AW-1:0]        ptr_next, slot_calc;
  logic [3:0]           dm1;
  logic [AW:0]          slot_sum;
  logic [AW-1:0]        dmod_tab [16];
  logic signed [32:0]   vt_diff, tgt_diff;
  logic signed [PW-1:0] vm_sh, om_sh, vt_sh;

  // Delay minus one, reduced modulo the ring depth
  for (genvar j = 0; j < 16; j++) begin : g_dmod
    assign dmod_tab[j] = AW'(j % RING_DEPTH);
  end

  assign dm1       = (item_i.delay == 4'd0) ? 4'd0 : item_i.delay - 4'd1;
  assign slot_sum  = {1'b0, ptr_q} + {1'b0, dmod_tab[dm1]};
  assign slot_calc = (slot_sum >= (AW+1)'(RING_DEPTH)) ?
                     AW'(slot_sum - (AW+1)'(RING_DEPTH)) : slot_sum[AW-1:0];
  assign ptr_next  = (ptr_q == AW'(RING_DEPTH - 1)) ? '0 : ptr_q + AW'(1);

  assign item_i.ready = (state_q == ST_IDLE);
  assign item_acc     = item_i.valid && item_i.ready;
  assign out_load     = (state_q == ST_T_A) && (!out_valid_q || result_o.ready);

  // Shifted operands for the rounding adder
  assign vm_sh    = {{(PW-48){vm_q[31]}}, vm_q, 16'd0};
  assign om_sh    = {{(PW-48){om_q[31]}}, om_q, 16'd0};
  assign vt_diff  = 33'(vm_q) - 33'(theta_q);
  assign vt_sh    = {{(PW-49){vt_diff[32]}}, vt_diff, 16'd0};
  assign tgt_diff = (add_sum[PW-1] ? atn_pkg::Q_ONE : 33'sd0) - 33'(om_q);

  // Select adder terms per step
  always_comb begin
    add_rnd = '0;
    add_b   = '0;
    case (state_q)
      ST_A_W: begin
        add_b = PW'(rd_q);
      end
      ST_T_D: begin
        add_rnd = atn_pkg::RND16;
        add_b   = -vm_sh;
      end
      ST_T_V: begin
        add_rnd = atn_pkg::RND16;
        add_b   = vm_sh;
      end
      ST_T_F: begin
        add_rnd = atn_pkg::RND16;
        add_b   = -vt_sh;
      end
      ST_T_A: begin
        add_rnd = atn_pkg::RND16;
        add_b   = om_sh;
      end
      default: begin
        add_rnd = '0;
        add_b   = '0;
      end
    endcase
  end

  assign add_sum = prod_q + add_rnd + add_b;

  assign mul_en = state_q inside {ST_A_M, ST_T_M1, ST_T_M2, ST_T_M3, ST_T_M4};

  // Sequencer: next state, operand loads, memory access and result load
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    ptr_d       = ptr_q;
    slot_d      = slot_q;
    vm_d        = vm_q;
    om_d        = om_q;
    fire_d      = fire_q;
    opa_d       = opa_q;
    opb_d       = opb_q;
    mem_we      = 1'b0;
    mem_wa      = ptr_q;
    mem_wd      = '0;
    mem_re      = 1'b0;
    mem_ra      = ptr_q;
    out_valid_d = out_valid_q && !result_o.ready;
    out_spike_d = out_spike_q;
    out_memb_d  = out_memb_q;
    out_adapt_d = out_adapt_q;

    case (state_q)
      ST_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        if (clr_q == AW'(RING_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (item_acc) begin
          mem_re = 1'b1;
          if (item_i.mode) begin
            mem_ra  = slot_calc;
            slot_d  = slot_calc;
            opa_d   = atn_pkg::OPA_W'(item_i.weight);
            opb_d   = {9'd0, item_i.multiplicity};
            state_d = ST_A_M;
          end else begin
            mem_ra  = ptr_q;
            state_d = ST_T_LD;
          end
        end
      end
      ST_A_M: begin
        state_d = ST_A_W;
      end
      ST_A_W: begin
        mem_we  = 1'b1;
        mem_wa  = slot_q;
        mem_wd  = atn_pkg::sat32(add_sum[atn_pkg::SAT_W-1:0]);
        state_d = ST_IDLE;
      end
      ST_T_LD: begin
        // consume the slot, clear it and advance the ring
        mem_we  = 1'b1;
        mem_wa  = ptr_q;
        ptr_d   = ptr_next;
        opa_d   = atn_pkg::OPA_W'(rd_q);
        opb_d   = {1'b0, gain_q};
        state_d = ST_T_M1;
      end
      ST_T_M1: begin
        state_d = ST_T_D;
      end
      ST_T_D: begin
        // drive minus membrane, rounded
        opa_d   = add_sum[56:16];
        opb_d   = {8'd0, mrate_q};
        state_d = ST_T_M2;
      end
      ST_T_M2: begin
        state_d = ST_T_V;
      end
      ST_T_V: begin
        vm_d    = atn_pkg::sat32(add_sum[PW-1:16]);
        opa_d   = atn_pkg::OPA_W'(om_q);
        opb_d   = {1'b0, alpha_q};
        state_d = ST_T_M3;
      end
      ST_T_M3: begin
        state_d = ST_T_F;
      end
      ST_T_F: begin
        // fire when the rounded alpha*omega lies below membrane minus threshold
        fire_d  = add_sum[PW-1];
        opa_d   = atn_pkg::OPA_W'(tgt_diff);
        opb_d   = {8'd0, arate_q};
        state_d = ST_T_M4;
      end
      ST_T_M4: begin
        state_d = ST_T_A;
      end
      ST_T_A: begin
        if (out_load) begin
          om_d        = atn_pkg::sat32(add_sum[PW-1:16]);
          out_valid_d = 1'b1;
          out_spike_d = fire_q;
          out_memb_d  = vm_q;
          out_adapt_d = atn_pkg::sat32(add_sum[PW-1:16]);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and neuron state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_q       <= '0;
      ptr_q       <= '0;
      vm_q        <= '0;
      om_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      ptr_q       <= ptr_d;
      vm_q        <= vm_d;
      om_q        <= om_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    slot_q      <= slot_d;
    fire_q      <= fire_d;
    opa_q       <= opa_d;
    opb_q       <= opb_d;
    out_spike_q <= out_spike_d;
    out_memb_q  <= out_memb_d;
    out_adapt_q <= out_adapt_d;
    if (mul_en) begin
      prod_q <= PW'(opa_q) * PW'(opb_q);
    end
  end

  // Delay ring: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= ring_mem[mem_ra];
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= atn_pkg::RST_INPUT_GAIN;
      mrate_q <= atn_pkg::RST_MEMBRANE_RATE;
      arate_q <= atn_pkg::RST_ADAPT_RATE;
      alpha_q <= atn_pkg::RST_ADAPT_STRENGTH;
      theta_q <= atn_pkg::RST_FIRE_THRESHOLD;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        atn_pkg::CFG_INPUT_GAIN:     gain_q  <= cfg_data_i[atn_pkg::GAIN_W-1:0];
        atn_pkg::CFG_MEMBRANE_RATE:  mrate_q <= cfg_data_i[atn_pkg::RATE_W-1:0];
        atn_pkg::CFG_ADAPT_RATE:     arate_q <= cfg_data_i[atn_pkg::RATE_W-1:0];
        atn_pkg::CFG_ADAPT_STRENGTH: alpha_q <= cfg_data_i[atn_pkg::GAIN_W-1:0];
        atn_pkg::CFG_FIRE_THRESHOLD: theta_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Drive the result channel
  assign result_o.valid      = out_valid_q;
  assign result_o.spike      = out_spike_q;
  assign result_o.membrane   = out_memb_q;
  assign result_o.adaptation = out_adapt_q;

  // A new result appears only from the last tick step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> ($past(state_q) == ST_T_A))
    else $error("result raised outside the final tick step");

  // The ring pointer moves only when a tick consumes its slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ptr_q != $past(ptr_q)) |-> ($past(state_q) == ST_T_LD))
    else $error("ring pointer moved outside a tick");

  // The membrane changes only in its update step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vm_q != $past(vm_q)) |-> ($past(state_q) == ST_T_V))
    else $error("membrane changed outside its update step");

  // A stalled final step holds until the previous result is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_T_A && out_valid_q && !result_o.ready) |=> (state_q == ST_T_A))
    else $error("tick finished over an untaken result");

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the adaptive-threshold neuron step: directed table, random phases.
module testbench;

  localparam int unsigned RING_SLOTS  = 16;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 100;
  localparam int unsigned SETTLE_CYC  = 24;
  localparam int unsigned HOLD_CYC    = 300;
  localparam int unsigned MAX_GAP     = 12;

  typedef enum logic {
    TICK    = 1'b0,
    ARRIVAL = 1'b1
  } item_mode_e;

  typedef struct packed {
    item_mode_e         mode;
    logic signed [31:0] weight;
    logic [15:0]        mult;
    logic [3:0]         delay;
  } nrn_item_t;

  typedef struct packed {
    logic               spike;
    logic signed [31:0] membrane;
    logic signed [31:0] adaptation;
  } nrn_result_t;

  typedef struct {
    nrn_item_t   item;
    bit          typed;
    nrn_result_t want;
  } stim_row_t;

  typedef struct {
    logic [31:0] gain;
    logic [31:0] mrate;
    logic [31:0] arate;
    logic [31:0] astr;
    logic [31:0] thr;
  } reg_set_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [atn_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [atn_pkg::CFG_DATA_W-1:0] cfg_data_i;

  atn_item_if   item_ch ();
  atn_result_if res_ch ();

  adaptive_threshold_neuron_step #(
    .RING_DEPTH(RING_SLOTS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_ch),
    .result_o   (res_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Neuron state and register copies kept by the predictor
  longint      slot_sum [RING_SLOTS];
  int unsigned read_slot;
  longint      membrane_q;
  longint      adapt_q;
  longint      k_gain;
  longint      k_mrate;
  longint      k_arate;
  longint      k_astr;
  longint      k_thr;

  nrn_result_t ticks_due [$];

  int unsigned err_count       = 0;
  int unsigned ticks_sent      = 0;
  int unsigned arrivals_sent   = 0;
  int unsigned results_checked = 0;
  int unsigned spikes_checked  = 0;
  int          send_idle_pct   = 0;
  int          recv_stall_pct  = 0;
  int          hold_req        = 0;
  int          hold_left       = 0;

  // Clock: 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Round a Q16.16 product back to Q16.16, ties toward plus infinity
  function automatic longint round_q16(input longint x);
    return (x + 64'sd32768) >>> 16;
  endfunction

  function automatic longint clamp_s32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic reset_model();
    foreach (slot_sum[i]) slot_sum[i] = 0;
    read_slot  = 0;
    membrane_q = 0;
    adapt_q    = 0;
    k_gain     = longint'(atn_pkg::RST_INPUT_GAIN);
    k_mrate    = longint'(atn_pkg::RST_MEMBRANE_RATE);
    k_arate    = longint'(atn_pkg::RST_ADAPT_RATE);
    k_astr     = longint'(atn_pkg::RST_ADAPT_STRENGTH);
    k_thr      = longint'(atn_pkg::RST_FIRE_THRESHOLD);
  endtask

  // Apply one accepted item to the neuron; a tick yields a result
  task automatic advance_neuron(input nrn_item_t it, output bit has_res,
                                output nrn_result_t res);
    longint      w;
    longint      m;
    longint      inp;
    longint      drive;
    longint      delta;
    longint      margin;
    longint      target;
    int unsigned d;
    int unsigned s;
    bit          fired;
    has_res = 1'b0;
    res     = '0;
    if (it.mode == ARRIVAL) begin
      w = longint'($signed(it.weight));
      m = longint'(it.mult);
      d = (it.delay == 4'd0) ? 1 : int'(it.delay);
      s = (read_slot + d - 1) % RING_SLOTS;
      slot_sum[s] = clamp_s32(slot_sum[s] + w * m);
    end else begin
      // Read and clear the current slot, then advance the ring
      inp = slot_sum[read_slot];
      slot_sum[read_slot] = 0;
      read_slot = (read_slot + 1) % RING_SLOTS;

      drive      = round_q16(k_gain * inp);
      delta      = round_q16((drive - membrane_q) * k_mrate);
      membrane_q = clamp_s32(membrane_q + delta);

      margin = membrane_q - round_q16(k_astr * adapt_q);
      fired  = margin > k_thr;

      target  = fired ? longint'(atn_pkg::Q_ONE) : 64'sd0;
      delta   = round_q16((target - adapt_q) * k_arate);
      adapt_q = clamp_s32(adapt_q + delta);

      res.spike      = fired;
      res.membrane   = membrane_q[31:0];
      res.adaptation = adapt_q[31:0];
      has_res        = 1'b1;
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Write one register and mirror it in the predictor
  task automatic write_reg(input logic [atn_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      atn_pkg::CFG_INPUT_GAIN:     k_gain  = longint'(data[atn_pkg::GAIN_W-1:0]);
      atn_pkg::CFG_MEMBRANE_RATE:  k_mrate = longint'(data[atn_pkg::RATE_W-1:0]);
      atn_pkg::CFG_ADAPT_RATE:     k_arate = longint'(data[atn_pkg::RATE_W-1:0]);
      atn_pkg::CFG_ADAPT_STRENGTH: k_astr  = longint'(data[atn_pkg::GAIN_W-1:0]);
      atn_pkg::CFG_FIRE_THRESHOLD: k_thr   = longint'($signed(data));
      default: ;
    endcase
  endtask

  // Offer one item after a random gap, wait for it to be taken, then predict
  task automatic push_item(input nrn_item_t it, input bit typed, input nrn_result_t want);
    int          gap;
    bit          has_res;
    nrn_result_t pred;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk_i);
    repeat (gap) begin
      item_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    item_ch.valid        <= 1'b1;
    item_ch.mode         <= it.mode;
    item_ch.weight       <= it.weight;
    item_ch.multiplicity <= it.mult;
    item_ch.delay        <= it.delay;
    do @(posedge clk_i); while (!item_ch.ready);
    advance_neuron(it, has_res, pred);
    if (has_res) begin
      ticks_due.push_back(typed ? want : pred);
      ticks_sent++;
    end else begin
      arrivals_sent++;
    end
  endtask

  // Drop valid, wait for every tick result, then let trailing arrivals settle
  task automatic wait_quiet();
    @(negedge clk_i);
    item_ch.valid <= 1'b0;
    while (ticks_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // Mostly moderate arrivals that make the neuron fire, some saturating noise
  function automatic nrn_item_t rand_item();
    nrn_item_t   it;
    int unsigned pick;
    int unsigned span;
    it.weight = $urandom;
    it.mult   = 16'($urandom);
    it.delay  = 4'($urandom);
    if ($urandom_range(99) < 42) begin
      it.mode = TICK;
      return it;
    end
    it.mode = ARRIVAL;
    pick = $urandom_range(99);
    if (pick < 50) begin
      span      = 1 << 17;
      it.weight = $urandom_range(0, 2 * span) - span;
      it.mult   = 16'($urandom_range(1, 32));
    end else if (pick < 70) begin
      span      = 1 << 20;
      it.weight = $urandom_range(0, 2 * span) - span;
      it.mult   = 16'($urandom_range(0, 255));
    end else if (pick >= 85) begin
      it.mult = 16'($urandom_range(0, 1));
    end
    if ($urandom_range(99) < 70) it.delay = 4'($urandom_range(0, 3));
    return it;
  endfunction

  function automatic stim_row_t mk_row(input item_mode_e mode, input logic [31:0] w,
                                       input logic [15:0] m, input logic [3:0] d,
                                       input bit typed);
    stim_row_t r;
    r.item.mode   = mode;
    r.item.weight = w;
    r.item.mult   = m;
    r.item.delay  = d;
    r.typed       = typed;
    r.want        = '0;
    return r;
  endfunction

  // Result side: stall at random, or hold off for a requested stretch
  initial begin : drive_ready
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk_i) begin : check_results
    nrn_result_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (ticks_due.size() == 0) begin
        report_mismatch("result with no tick outstanding");
      end else begin
        want = ticks_due.pop_front();
        results_checked++;
        if (res_ch.spike) spikes_checked++;
        if (res_ch.spike !== want.spike)
          report_mismatch($sformatf("spike got %b want %b", res_ch.spike, want.spike));
        if (res_ch.membrane !== want.membrane)
          report_mismatch($sformatf("membrane got %0d want %0d",
                                    res_ch.membrane, want.membrane));
        if (res_ch.adaptation !== want.adaptation)
          report_mismatch($sformatf("adaptation got %0d want %0d",
                                    res_ch.adaptation, want.adaptation));
      end
    end
  end

  initial begin : run_stimulus
    stim_row_t rows [$];
    reg_set_t  sets [PHASES];
    nrn_item_t it;

    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = '0;
    cfg_data_i           = '0;
    item_ch.valid        = 1'b0;
    item_ch.mode         = TICK;
    item_ch.weight       = '0;
    item_ch.multiplicity = '0;
    item_ch.delay        = '0;
    reset_model();

    // Register settings, one per random phase
    sets[0] = '{32'd655, 32'd26214, 32'd6554, 32'd458752, 32'd11796};
    sets[1] = '{32'd6554, 32'd65536, 32'd65536, 32'd65536, 32'd65536};
    sets[2] = '{32'hFF_FFFF, 32'h1_FFFF, 32'h1_FFFF, 32'hFF_FFFF, 32'h7FFF_FFFF};
    sets[3] = '{32'd0, 32'd0, 32'd0, 32'd0, 32'h8000_0000};
    sets[4] = '{32'd1, 32'd1, 32'd1, 32'd1, 32'd0};
    sets[5] = '{32'd13100, 32'd26214, 32'd6554, 32'd458752, 32'd11796};
    sets[6] = '{32'd3000, 32'd40000, 32'd20000, 32'h0A_0000, 32'hFFFF_0000};
    sets[7] = '{$urandom & 32'hFF_FFFF, $urandom & 32'h1_FFFF, $urandom & 32'h1_FFFF,
                $urandom & 32'hFF_FFFF, $urandom};

    // Directed items under reset register values
    rows.push_back(mk_row(TICK,    32'h0000_0000, 16'h0000, 4'd0,  1'b1)); // empty ring
    rows.push_back(mk_row(ARRIVAL, 32'h7FFF_FFFF, 16'hFFFF, 4'd1,  1'b0)); // saturate high
    rows.push_back(mk_row(ARRIVAL, 32'h7FFF_FFFF, 16'hFFFF, 4'd1,  1'b0));
    rows.push_back(mk_row(TICK,    32'hFFFF_FFFF, 16'hFFFF, 4'd15, 1'b0));
    rows.push_back(mk_row(ARRIVAL, 32'h8000_0000, 16'hFFFF, 4'd2,  1'b0)); // saturate low
    rows.push_back(mk_row(ARRIVAL, 32'h7FFF_FFFF, 16'h0000, 4'd15, 1'b0)); // zero count
    rows.push_back(mk_row(ARRIVAL, 32'h0001_0000, 16'h0003, 4'd0,  1'b0)); // zero delay
    rows.push_back(mk_row(TICK,    32'h0000_0000, 16'h0000, 4'd0,  1'b0));
    rows.push_back(mk_row(TICK,    32'h0000_0000, 16'h0000, 4'd0,  1'b0));
    rows.push_back(mk_row(ARRIVAL, 32'hFFFF_FFFF, 16'h0001, 4'd3,  1'b0)); // inhibitory
    rows.push_back(mk_row(ARRIVAL, 32'h0000_0001, 16'hFFFF, 4'd3,  1'b0));
    rows.push_back(mk_row(ARRIVAL, 32'h5555_5555, 16'hAAAA, 4'd15, 1'b0));
    rows.push_back(mk_row(ARRIVAL, 32'hAAAA_AAAA, 16'h5555, 4'd14, 1'b0));
    rows.push_back(mk_row(TICK,    32'h0000_0000, 16'h0000, 4'd0,  1'b0));
    rows.push_back(mk_row(ARRIVAL, 32'h0001_0000, 16'h03E8, 4'd1,  1'b0)); // strong drive
    repeat (5) rows.push_back(mk_row(TICK, 32'h0, 16'h0, 4'd0, 1'b0));

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) push_item(rows[i].item, rows[i].typed, rows[i].want);

    // Random phases: new register setting and idle mix each time
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_quiet();
      write_reg(atn_pkg::CFG_INPUT_GAIN,     sets[ph].gain);
      write_reg(atn_pkg::CFG_MEMBRANE_RATE,  sets[ph].mrate);
      write_reg(atn_pkg::CFG_ADAPT_RATE,     sets[ph].arate);
      write_reg(atn_pkg::CFG_ADAPT_STRENGTH, sets[ph].astr);
      write_reg(atn_pkg::CFG_FIRE_THRESHOLD, sets[ph].thr);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      // Hold the output back long enough for the block to back up its input
      if (ph == 0) hold_req = HOLD_CYC;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 3 && n == PHASE_ITEMS / 2) wait_quiet();
        it = rand_item();
        push_item(it, 1'b0, '0);
      end
    end

    wait_quiet();
    $display("testbench: %0d ticks and %0d spike arrivals over %0d register settings",
             ticks_sent, arrivals_sent, PHASES);
    $display("testbench: %0d results checked, %0d spiking; idle mixes and a %0d-cycle hold-off",
             results_checked, spikes_checked, HOLD_CYC);
    if (err_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin : watchdog
    #4_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
